// ----- sv/slrd_pkg.sv -----
// package for the shuffled lcg range draw unit
// holds opcodes, generator constants, fsm states and controller/datapath structs
// no dependencies
`default_nettype none

package slrd_pkg;

    localparam int DATA_W    = 32;
    localparam int TBL_DEPTH = 32;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int IDX_LSB   = 26;
    localparam int PROD_W    = 46;
    localparam int CNT_W     = 6;

    localparam logic [CNT_W-1:0] WARM_LAST = 6'd39;
    localparam logic [CNT_W-1:0] REM_LAST  = 6'd31;

    localparam logic [14:0] LCG_A   = 15'd16807;
    localparam logic [31:0] LCG_M   = 32'h7FFF_FFFF;
    localparam logic [31:0] LIM_TOP = 32'h7FFF_FFFF;
    localparam logic [31:0] HALF    = 32'h8000_0000;

    localparam logic signed [31:0] SEED_ADJ = 32'sd22261048;
    localparam logic signed [31:0] SEED_LO  = -32'sd999;
    localparam logic signed [31:0] SEED_HI  = 32'sd1000;
    localparam logic signed [31:0] SEED_MIN = 32'sh8000_0000;

    typedef enum logic
    {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } slrd_op_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_LIMIT,
        S_GEN,
        S_FILL_MUL,
        S_FILL_RED,
        S_STEP_MUL,
        S_STEP_RED,
        S_CHECK,
        S_MOD,
        S_RESULT,
        S_OUT
    } slrd_state_t;

    typedef struct packed
    {
        logic              seed_load;
        logic              draw_load;
        logic              res_lo;
        logic              rem_start;
        logic              rem_sel_val;
        logic              rem_shift;
        logic              limit_load;
        logic              fill_init;
        logic              mul;
        logic              reduce;
        logic              last_from_seed;
        logic              step_commit;
        logic              tbl_read;
        logic              tbl_write;
        logic              tbl_wr_fill;
        logic [TBL_AW-1:0] fill_idx;
        logic              res_mod;
        logic              out_load;
    } slrd_cmd_t;

    typedef struct packed
    {
        logic fill_needed;
        logic empty_range;
        logic reject;
    } slrd_sts_t;

endpackage

`default_nettype wire

// ----- sv/slrd_req_if.sv -----
// request channel of the shuffled lcg range draw unit
// valid/ready handshake with opcode, time value and range bounds; no dependencies
`default_nettype none

interface slrd_req_if;
    logic               valid;
    logic               ready;
    logic [0:0]         opcode;
    logic signed [31:0] time_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;

    modport source (output valid, opcode, time_value, range_low, range_high, input ready);
    modport sink   (input valid, opcode, time_value, range_low, range_high, output ready);
endinterface

`default_nettype wire

// ----- sv/slrd_rsp_if.sv -----
// result channel of the shuffled lcg range draw unit
// valid/ready handshake carrying the drawn value; no dependencies
`default_nettype none

interface slrd_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] draw_value;

    modport source (output valid, draw_value, input ready);
    modport sink   (input valid, draw_value, output ready);
endinterface

`default_nettype wire

// ----- sv/slrd_datapath.sv -----
// datapath: seed and last-output registers, multiply/reduce step, shuffle table,
// bit-serial remainder unit, bounds and result registers; uses slrd_pkg
`default_nettype none

module slrd_datapath
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire slrd_pkg::slrd_cmd_t cmd,
    output slrd_pkg::slrd_sts_t      sts,
    input  wire logic signed [31:0]  time_value,
    input  wire logic signed [31:0]  range_low,
    input  wire logic signed [31:0]  range_high,
    output logic signed [31:0]       draw_value
);

    logic signed [31:0] seed_reg, seed_next;
    logic [31:0]        last_reg, last_next;
    logic [slrd_pkg::PROD_W-1:0] prod_reg;
    logic [31:0]        rd_reg;
    logic [31:0]        tbl_mem [slrd_pkg::TBL_DEPTH];

    logic signed [31:0] lo_reg;
    logic [32:0]        range_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dvd_reg;
    logic [31:0]        limit_reg;
    logic [31:0]        res_reg;
    logic [31:0]        out_data_reg;

    logic signed [31:0] neg_time;
    logic signed [31:0] reseed_val;
    logic signed [31:0] fill_seed;
    logic [31:0]        red_sum;
    logic [30:0]        red_val;
    logic [32:0]        trial;
    logic [slrd_pkg::TBL_AW-1:0] idx;
    logic [slrd_pkg::TBL_AW-1:0] wr_addr;

    // reseed value: negate, then push small magnitudes away
    always_comb
    begin
        neg_time = -time_value;
        if (neg_time >= slrd_pkg::SEED_LO && neg_time <= slrd_pkg::SEED_HI)
        begin
            reseed_val = neg_time - slrd_pkg::SEED_ADJ;
        end
        else
        begin
            reseed_val = neg_time;
        end
    end

    // table refill start seed: negated seed, or one when that is not positive
    assign fill_seed = (seed_reg[31] && seed_reg != slrd_pkg::SEED_MIN) ? -seed_reg : 32'sd1;

    // 16807 * x mod (2^31 - 1) by folding the high bits back in
    assign red_sum = {1'b0, prod_reg[30:0]} + {17'd0, prod_reg[45:31]};
    assign red_val = (red_sum >= slrd_pkg::LCG_M) ? 31'(red_sum - slrd_pkg::LCG_M)
                                                   : red_sum[30:0];

    assign idx     = last_reg[slrd_pkg::IDX_LSB +: slrd_pkg::TBL_AW];
    assign wr_addr = cmd.tbl_wr_fill ? cmd.fill_idx : idx;
    assign trial   = {rem_reg, dvd_reg[31]};

    always_comb
    begin
        seed_next = seed_reg;
        if (cmd.seed_load)
        begin
            seed_next = reseed_val;
        end
        else if (cmd.fill_init)
        begin
            seed_next = fill_seed;
        end
        else if (cmd.reduce)
        begin
            seed_next = {1'b0, red_val};
        end
    end

    always_comb
    begin
        last_next = last_reg;
        if (cmd.last_from_seed)
        begin
            last_next = {1'b0, red_val};
        end
        else if (cmd.step_commit)
        begin
            last_next = rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
            last_reg <= last_next;
        end
    end

    // shuffle table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            tbl_mem[wr_addr] <= {1'b0, red_val};
        end
        if (cmd.tbl_read)
        begin
            rd_reg <= tbl_mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= slrd_pkg::PROD_W'(seed_reg[30:0]) * slrd_pkg::PROD_W'(slrd_pkg::LCG_A);
        end
        if (cmd.draw_load)
        begin
            lo_reg    <= range_low;
            range_reg <= {range_high[31], range_high} - {range_low[31], range_low} + 33'd1;
        end
        if (cmd.rem_start)
        begin
            rem_reg <= '0;
            dvd_reg <= cmd.rem_sel_val ? last_reg : slrd_pkg::HALF;
        end
        else if (cmd.rem_shift)
        begin
            rem_reg <= (trial >= range_reg) ? 32'(trial - range_reg) : trial[31:0];
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
        if (cmd.limit_load)
        begin
            limit_reg <= slrd_pkg::LIM_TOP - rem_reg;
        end
        if (cmd.res_lo)
        begin
            res_reg <= range_low;
        end
        else if (cmd.res_mod)
        begin
            res_reg <= lo_reg + rem_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.fill_needed = seed_reg[31] || seed_reg == '0 || last_reg == '0;
        sts.empty_range = range_high < range_low;
        sts.reject      = last_reg > limit_reg;
    end

    assign draw_value = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/slrd_ctrl.sv -----
// controller fsm: sequences reseed, limit computation, table refill, generator
// steps, rejection and final remainder; owns the result valid flag; uses slrd_pkg
`default_nettype none

module slrd_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [0:0]          in_opcode,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire slrd_pkg::slrd_sts_t sts,
    output slrd_pkg::slrd_cmd_t      cmd
);

    slrd_pkg::slrd_state_t state_reg, state_next;
    logic [slrd_pkg::CNT_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slrd_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            slrd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == slrd_pkg::OP_RESEED)
                    begin
                        cmd.seed_load = 1'b1;
                    end
                    else if (sts.empty_range)
                    begin
                        cmd.res_lo = 1'b1;
                        state_next = slrd_pkg::S_OUT;
                    end
                    else
                    begin
                        cmd.draw_load = 1'b1;
                        cmd.rem_start = 1'b1;
                        count_next    = slrd_pkg::REM_LAST;
                        state_next    = slrd_pkg::S_LIMIT;
                    end
                end
            end

            slrd_pkg::S_LIMIT:
            begin
                cmd.rem_shift = 1'b1;
                if (count_reg == '0)
                begin
                    state_next = slrd_pkg::S_GEN;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end

            slrd_pkg::S_GEN:
            begin
                cmd.limit_load = 1'b1;
                if (sts.fill_needed)
                begin
                    cmd.fill_init = 1'b1;
                    count_next    = slrd_pkg::WARM_LAST;
                    state_next    = slrd_pkg::S_FILL_MUL;
                end
                else
                begin
                    state_next = slrd_pkg::S_STEP_MUL;
                end
            end

            slrd_pkg::S_FILL_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = slrd_pkg::S_FILL_RED;
            end

            slrd_pkg::S_FILL_RED:
            begin
                cmd.reduce = 1'b1;
                // only the last table-depth warm-up steps land in the table
                if (count_reg < slrd_pkg::CNT_W'(slrd_pkg::TBL_DEPTH))
                begin
                    cmd.tbl_write   = 1'b1;
                    cmd.tbl_wr_fill = 1'b1;
                    cmd.fill_idx    = count_reg[slrd_pkg::TBL_AW-1:0];
                end
                if (count_reg == '0)
                begin
                    cmd.last_from_seed = 1'b1;
                    state_next         = slrd_pkg::S_STEP_MUL;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = slrd_pkg::S_FILL_MUL;
                end
            end

            slrd_pkg::S_STEP_MUL:
            begin
                cmd.mul      = 1'b1;
                cmd.tbl_read = 1'b1;
                state_next   = slrd_pkg::S_STEP_RED;
            end

            slrd_pkg::S_STEP_RED:
            begin
                cmd.reduce      = 1'b1;
                cmd.tbl_write   = 1'b1;
                cmd.step_commit = 1'b1;
                state_next      = slrd_pkg::S_CHECK;
            end

            slrd_pkg::S_CHECK:
            begin
                if (sts.reject)
                begin
                    state_next = slrd_pkg::S_GEN;
                end
                else
                begin
                    cmd.rem_start   = 1'b1;
                    cmd.rem_sel_val = 1'b1;
                    count_next      = slrd_pkg::REM_LAST;
                    state_next      = slrd_pkg::S_MOD;
                end
            end

            slrd_pkg::S_MOD:
            begin
                cmd.rem_shift = 1'b1;
                if (count_reg == '0)
                begin
                    state_next = slrd_pkg::S_RESULT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end

            slrd_pkg::S_RESULT:
            begin
                cmd.res_mod = 1'b1;
                state_next  = slrd_pkg::S_OUT;
            end

            slrd_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = slrd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = slrd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- sv/shuffled_lcg_range_draw_unit.sv -----
// shuffled lcg range draw unit, top level
// ties the request/result channels to slrd_ctrl and slrd_datapath; uses slrd_pkg,
// slrd_req_if and slrd_rsp_if
//
// usage
//   req carries one request: opcode 1 reseeds from time_value and returns
//   nothing; opcode 0 draws a value in range_low..range_high and returns one
//   result on rsp (range_low itself when range_high is below range_low).
//   a reseed loads the seed and the unit stays idle. an empty-range draw loads
//   range_low into the result and then the output register. a normal draw is
//   accepted, works out the rejection limit, runs generator attempts (each a
//   multiply, a reduce with table swap and a rejection check; the shuffle
//   table is refilled first when needed: 40 warm-up steps of multiply and
//   reduce), then the final remainder, and loads the output register.
//   the bit-serial remainder unit computes one quotient bit per cycle.
//   one request is worked on at a time; req.ready is high only while idle.
//   the result sits in an output register, so the next request is taken
//   while rsp is stalled; a following draw waits at its end until rsp frees.
//   reset clears the seed and last output, which forces a table refill on the
//   first draw; the table itself is not cleared.
`default_nettype none

module shuffled_lcg_range_draw_unit
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    slrd_req_if.sink   req,
    slrd_rsp_if.source rsp
);

    slrd_pkg::slrd_cmd_t cmd;
    slrd_pkg::slrd_sts_t sts;

    slrd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    slrd_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .time_value (req.time_value),
        .range_low  (req.range_low),
        .range_high (req.range_high),
        .draw_value (rsp.draw_value)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for the shuffled lcg range draw unit: directed table, then random requests,
// every draw checked against a built-in ran1 predictor; depends on slrd_pkg,
// slrd_req_if, slrd_rsp_if and shuffled_lcg_range_draw_unit
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam longint GEN_Q      = 127773;
    localparam longint GEN_R      = 2836;
    localparam longint GEN_A      = 16807;
    localparam longint GEN_M      = 2147483647;
    localparam int     WARMUP     = 40;
    localparam int     RAND_COUNT = 1500;
    localparam int     DRAIN_AT   = 700;
    localparam int     SETTLE     = 200;
    localparam longint CYCLE_CAP  = 1500000;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed
    {
        slrd_pkg::slrd_op_t op;
        logic signed [31:0] tv;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               fixed;
        logic signed [31:0] fixed_value;
    } stim_row_t;

    // fixed_value is typed in only where the answer is obvious
    stim_row_t dir_rows [25] = '{
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd0,   32'sd99,        1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd12345,   32'sd5,   32'sd4,         1'b1, 32'sd5},
        '{slrd_pkg::OP_DRAW,   -32'sd1,      S32_MAX,  S32_MIN,        1'b1, S32_MAX},
        '{slrd_pkg::OP_DRAW,   32'sd0,       -32'sd7,  -32'sd7,        1'b1, -32'sd7},
        '{slrd_pkg::OP_DRAW,   S32_MIN,      S32_MIN,  S32_MAX,        1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       S32_MAX,  S32_MAX,        1'b1, S32_MAX},
        '{slrd_pkg::OP_DRAW,   32'sd0,       S32_MIN,  S32_MIN,        1'b1, S32_MIN},
        '{slrd_pkg::OP_RESEED, 32'sd0,       32'sd0,   32'sd0,         1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd1,   32'sd6,         1'b0, 32'sd0},
        '{slrd_pkg::OP_RESEED, -32'sd1000,   -32'sd1,  32'sd3,         1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd0,   32'sd1000,      1'b0, 32'sd0},
        '{slrd_pkg::OP_RESEED, 32'sd999,     32'sd0,   32'sd0,         1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       -32'sd50, 32'sd50,        1'b0, 32'sd0},
        '{slrd_pkg::OP_RESEED, 32'sd1000,    32'sd0,   32'sd0,         1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd0,   32'sd255,       1'b0, 32'sd0},
        '{slrd_pkg::OP_RESEED, -32'sd1001,   32'sd0,   32'sd0,         1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd0,   32'sh4000_0000, 1'b0, 32'sd0},
        '{slrd_pkg::OP_RESEED, S32_MIN,      S32_MAX,  S32_MIN,        1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       S32_MIN,  32'sd0,         1'b0, 32'sd0},
        '{slrd_pkg::OP_RESEED, S32_MAX,      -32'sd1,  -32'sd1,        1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       -32'sd1,  S32_MAX,        1'b0, 32'sd0},
        '{slrd_pkg::OP_RESEED, -32'sd2147483647, 32'sd0, 32'sd0,       1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd0,   32'sd9,         1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd0,   32'sd9,         1'b0, 32'sd0},
        '{slrd_pkg::OP_DRAW,   32'sd0,       32'sd0,   S32_MAX,        1'b0, 32'sd0}
    };

    logic clk;
    logic rst_n;

    slrd_req_if req_ch ();
    slrd_rsp_if rsp_ch ();

    shuffled_lcg_range_draw_unit u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // generator state mirrored by the predictor
    longint gen_seed;
    longint gen_last;
    longint gen_table [slrd_pkg::TBL_DEPTH];

    logic signed [31:0] expected_draws [$];

    int     n_reseeds;
    int     n_draws;
    int     n_checked;
    int     n_errors;
    int     stall_left;
    int     stall_pick;
    bit     calm;
    longint cycles;

    logic signed [31:0] want_value;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint schrage_step(input longint x);
        longint k;
        longint r;
        k = x / GEN_Q;
        r = GEN_A * (x - k * GEN_Q) - GEN_R * k;
        if (r < 0)
        begin
            r += GEN_M;
        end
        return r;
    endfunction

    function automatic longint next_shuffled();
        longint n;
        int     j;
        int     idx;
        // refill when the seed is non-positive or the last output is zero
        if (gen_seed <= 0 || gen_last == 0)
        begin
            n = (gen_seed == -64'sd2147483648) ? gen_seed : -gen_seed;
            gen_seed = (n < 1) ? 1 : n;
            for (j = WARMUP - 1; j >= 0; j--)
            begin
                gen_seed = schrage_step(gen_seed);
                if (j < slrd_pkg::TBL_DEPTH)
                begin
                    gen_table[j] = gen_seed;
                end
            end
            gen_last = gen_table[0];
        end
        gen_seed = schrage_step(gen_seed);
        idx = int'((gen_last >> slrd_pkg::IDX_LSB) & (slrd_pkg::TBL_DEPTH - 1));
        gen_last = gen_table[idx];
        gen_table[idx] = gen_seed;
        return gen_last;
    endfunction

    function automatic void predict_request(input slrd_pkg::slrd_op_t op,
                                            input logic signed [31:0] tv,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi,
                                            output bit produces,
                                            output logic signed [31:0] value);
        logic signed [31:0] neg_tv;
        longint s;
        longint lo_l;
        longint hi_l;
        longint span;
        longint limit;
        longint v;
        longint res;
        produces = 1'b0;
        value    = '0;
        if (op == slrd_pkg::OP_RESEED)
        begin
            neg_tv = -tv;
            s = neg_tv;
            if (s <= slrd_pkg::SEED_HI && s >= slrd_pkg::SEED_LO)
            begin
                s -= slrd_pkg::SEED_ADJ;
            end
            gen_seed = s;
        end
        else
        begin
            produces = 1'b1;
            lo_l = lo;
            hi_l = hi;
            value = lo;
            if (hi_l >= lo_l)
            begin
                span  = hi_l - lo_l + 1;
                // wraps to all ones for spans above 2^31, so nothing is rejected
                limit = (64'sh7FFF_FFFF - (64'sh8000_0000 % span)) & 64'shFFFF_FFFF;
                do
                begin
                    v = next_shuffled();
                end
                while (v > limit);
                res = lo_l + v % span;
                value = res[31:0];
            end
        end
    endfunction

    task automatic issue_request(input slrd_pkg::slrd_op_t op, input logic signed [31:0] tv,
                                 input logic signed [31:0] lo, input logic signed [31:0] hi,
                                 input bit fixed, input logic signed [31:0] fixed_value,
                                 input int unsigned gap, input bit drain);
        bit produces;
        logic signed [31:0] value;
        if (drain && gap == 0)
        begin
            gap = 1;
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            if (drain)
            begin
                while (expected_draws.size() > 0)
                begin
                    @(posedge clk);
                end
            end
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.time_value <= tv;
        req_ch.range_low  <= lo;
        req_ch.range_high <= hi;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        predict_request(op, tv, lo, hi, produces, value);
        if (produces)
        begin
            expected_draws.push_back(fixed ? fixed_value : value);
            n_draws++;
        end
        else
        begin
            n_reseeds++;
        end
    endtask

    // result side: check each accepted result, then stall a random while
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_draws.size() == 0)
            begin
                $error("draw_value: no result expected, actual %0d", rsp_ch.draw_value);
                n_errors++;
            end
            else
            begin
                want_value = expected_draws.pop_front();
                n_checked++;
                if (rsp_ch.draw_value !== want_value)
                begin
                    $error("draw_value mismatch: expected %0d, actual %0d",
                           want_value, rsp_ch.draw_value);
                    n_errors++;
                end
            end
            stall_pick = calm ? 0 : $urandom_range(0, 9);
            if (stall_pick != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_pick;
            end
        end
        else if (!rsp_ch.ready)
        begin
            if (stall_left <= 1)
            begin
                rsp_ch.ready <= 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic signed [31:0] tv;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] tmp;
        slrd_pkg::slrd_op_t op;
        int unsigned pick;
        int unsigned width;
        int unsigned gap;
        int i;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = slrd_pkg::OP_DRAW;
        req_ch.time_value = '0;
        req_ch.range_low  = '0;
        req_ch.range_high = '0;
        rsp_ch.ready      = 1'b0;
        gen_seed          = 0;
        gen_last          = 0;
        n_reseeds         = 0;
        n_draws           = 0;
        n_checked         = 0;
        n_errors          = 0;
        stall_left        = 0;
        calm              = 1'b0;
        cycles            = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            issue_request(dir_rows[r].op, dir_rows[r].tv, dir_rows[r].lo, dir_rows[r].hi,
                          dir_rows[r].fixed, dir_rows[r].fixed_value,
                          $urandom_range(0, 9), 1'b0);
        end

        for (i = 0; i < RAND_COUNT; i++)
        begin
            // every fourth block of 100 requests runs with no idling on either side, but for the drain at DRAIN_AT
            calm = ((i / 100) % 4) == 3;
            pick = $urandom_range(0, 99);
            op   = slrd_pkg::OP_DRAW;
            tv   = $urandom;
            lo   = $urandom;
            hi   = $urandom;
            if (pick < 12)
            begin
                op = slrd_pkg::OP_RESEED;
                if (pick < 6)
                begin
                    // mostly lands in the small-seed window that gets the offset (tv of 1000 falls just outside it)
                    tv = int'($urandom_range(0, 2000)) - 1000;
                end
                else if (pick == 6)
                begin
                    case ($urandom_range(0, 2))
                        0: tv = S32_MIN;
                        1: tv = S32_MAX;
                        default: tv = -32'sd2147483647;
                    endcase
                end
            end
            else if (pick < 22)
            begin
                if (hi >= lo)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                if (hi == lo)
                begin
                    hi = lo - 1;
                end
                if (lo == S32_MIN)
                begin
                    lo = 32'sd0;
                    hi = -32'sd1;
                end
            end
            else if (pick < 70)
            begin
                width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 15);
                hi = lo + width;
            end
            else if (hi < lo)
            begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            gap = calm ? 0 : $urandom_range(0, 9);
            issue_request(op, tv, lo, hi, 1'b0, 32'sd0, gap, i == DRAIN_AT);
        end

        req_ch.valid <= 1'b0;
        calm = 1'b0;
        while (expected_draws.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d reseeds and %0d draws (directed table plus random mix)",
                 n_reseeds, n_draws);
        $display("compared %0d results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
